/* rtl/bchpc_pkg.sv */
// Shared constants, types and syndrome helpers for the BCH(31,21) corrector.
`default_nettype none

package bchpc_pkg;

  localparam int CODE_N = 31;
  localparam int CODE_K = 21;
  localparam int WORD_W = CODE_N + 1;
  localparam int REM_W  = CODE_N - CODE_K;
  localparam int SYN_W  = REM_W + 1;

  localparam logic [REM_W:0] GEN_POLY = 11'h769;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SYN_W-1:0]  syn_t;
  typedef syn_t col_tab_t [WORD_W];

  typedef enum logic [1:0] {
    ST_CLEAN = 2'd0,
    ST_ONE   = 2'd1,
    ST_TWO   = 2'd2,
    ST_FAIL  = 2'd3
  } status_t;

  typedef struct packed {
    word_t single_mask;
    word_t pair_mask;
  } loc_t;

  function automatic col_tab_t gen_cols();
    col_tab_t         tab;
    logic [REM_W-1:0] rem;
    rem    = REM_W'(1);
    tab[0] = syn_t'(1) << REM_W;
    for (int i = 1; i < WORD_W; i++) begin
      tab[i] = {1'b1, rem};
      if (rem[REM_W-1]) begin
        rem = (rem << 1) ^ GEN_POLY[REM_W-1:0];
      end else begin
        rem = rem << 1;
      end
    end
    return tab;
  endfunction

  localparam col_tab_t COLS = gen_cols();

  function automatic syn_t word_syndrome(word_t w);
    syn_t s;
    s = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) begin
        s = s ^ COLS[i];
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/bch_31_21_parity_corrector.sv */
// Top level: three-stage BCH(31,21) plus parity codeword corrector.
//
//  channel | ports                                  | dir
//  --------+----------------------------------------+-----
//  in      | in_valid, in_ready, in_codeword_in     | in
//  out     | out_valid, out_ready, out_codeword_out,| out
//          | out_status                             |
//
// One word enters per cycle unless the output stalls; each word passes in order
// through syndrome, locator masks, correction into the output register.
// Reset clears the stage valid bits; payload registers are not reset.
// A stall holds the full stages next to the output; gaps before them fill.
`default_nettype none

module bch_31_21_parity_corrector
  import bchpc_pkg::*;
(
  input  var logic        clk,
  input  var logic        rst_n,
  input  var logic        in_valid,
  output var logic        in_ready,
  input  var logic [31:0] in_codeword_in,
  output var logic        out_valid,
  input  var logic        out_ready,
  output var logic [31:0] out_codeword_out,
  output var logic [1:0]  out_status
);

  logic    a_vld_r, a_vld_nxt;
  logic    b_vld_r, b_vld_nxt;
  logic    c_vld_r, c_vld_nxt;
  logic    a_en, b_en, c_en;

  word_t   a_word_r;
  syn_t    a_syn_r;
  word_t   b_word_r;
  logic    b_zero_r;
  loc_t    b_loc_r;
  word_t   c_word_r;
  status_t c_status_r;

  loc_t    loc;
  word_t   fix_word;
  status_t fix_status;

  assign c_en = !c_vld_r || out_ready;
  assign b_en = !b_vld_r || c_en;
  assign a_en = !a_vld_r || b_en;

  assign a_vld_nxt = a_en ? in_valid : a_vld_r;
  assign b_vld_nxt = b_en ? a_vld_r  : b_vld_r;
  assign c_vld_nxt = c_en ? b_vld_r  : c_vld_r;

  bchpc_locator u_locator (
    .syn (a_syn_r),
    .loc (loc)
  );

  always_comb begin
    priority if (b_zero_r) begin
      fix_word   = b_word_r;
      fix_status = ST_CLEAN;
    end else if (|b_loc_r.single_mask) begin
      fix_word   = b_word_r ^ b_loc_r.single_mask;
      fix_status = ST_ONE;
    end else if (|b_loc_r.pair_mask) begin
      fix_word   = b_word_r ^ b_loc_r.pair_mask;
      fix_status = ST_TWO;
    end else begin
      fix_word   = b_word_r;
      fix_status = ST_FAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
      c_vld_r <= c_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_word_r <= in_codeword_in;
      a_syn_r  <= word_syndrome(in_codeword_in);
    end
    if (b_en) begin
      b_word_r <= a_word_r;
      b_zero_r <= (a_syn_r == '0);
      b_loc_r  <= loc;
    end
    if (c_en) begin
      c_word_r   <= fix_word;
      c_status_r <= fix_status;
    end
  end

  assign in_ready         = a_en;
  assign out_valid        = c_vld_r;
  assign out_codeword_out = c_word_r;
  assign out_status       = c_status_r;

endmodule

`default_nettype wire

/* rtl/bchpc_locator.sv */
// Error locator: maps a syndrome to single-flip and double-flip bit masks.
`default_nettype none

module bchpc_locator
  import bchpc_pkg::*;
(
  input  var syn_t syn,
  output var loc_t loc
);

  always_comb begin
    loc = '0;
    for (int k = 0; k < WORD_W; k++) begin
      loc.single_mask[k] = (syn == COLS[k]);
      for (int j = 0; j < WORD_W; j++) begin
        if (j != k) begin
          if (syn == (COLS[k] ^ COLS[j])) begin
            loc.pair_mask[k] = 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
